// File: rtl/core/rei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rei_pkg;

	// Fraction bits dropped when Q.32 partial results are floored to Q.16,
	// and again when Q.24 offsets are rounded back to Q.8 coordinates.
	localparam int FIX_SHIFT = 16;

	// The unit of the quadratic form entries sits at bit 24 (Q8.24).
	localparam int ONE_SHIFT = 24;

	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_ONE  = 2'd1;
	localparam logic [1:0] HIT_TWO  = 2'd2;

	typedef enum logic [2:0] {
		REG_FORM_XX = 3'd0,
		REG_FORM_YY = 3'd1,
		REG_FORM_ZZ = 3'd2,
		REG_FORM_XY = 3'd3,
		REG_FORM_XZ = 3'd4,
		REG_FORM_YZ = 3'd5,
		REG_CENTRE  = 3'd6
	} reg_idx_t;

endpackage

`default_nettype wire

// File: rtl/core/ray_ellipsoid_intersection.sv
`timescale 1ns / 1ps
`default_nettype none

// A taken request runs through the front stages, the square root stages and the divider
// stages in turn before done rises.
// Throughput: one request per cycle; busy is always low and the receiver cannot stall.
// Reset: arst_n clears all valid bits and loads the form with the identity and a zero centre.
module ray_ellipsoid_intersection #(
	parameter int COORD_WIDTH = 16,
	parameter int FORM_WIDTH  = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_addr,
	input  wire logic [((FORM_WIDTH > 3*COORD_WIDTH) ? FORM_WIDTH : 3*COORD_WIDTH)-1:0]
	                                           cfg_wdata,

	// Request side.
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [COORD_WIDTH-1:0] start_x,
	input  wire logic signed [COORD_WIDTH-1:0] start_y,
	input  wire logic signed [COORD_WIDTH-1:0] start_z,
	input  wire logic signed [COORD_WIDTH-1:0] heading_x,
	input  wire logic signed [COORD_WIDTH-1:0] heading_y,
	input  wire logic signed [COORD_WIDTH-1:0] heading_z,

	// Result side, one cycle strobe.
	output logic                               done,
	output logic [1:0]                         hit_count,
	output logic signed [COORD_WIDTH-1:0]      near_x,
	output logic signed [COORD_WIDTH-1:0]      near_y,
	output logic signed [COORD_WIDTH-1:0]      near_z,
	output logic signed [COORD_WIDTH-1:0]      far_x,
	output logic signed [COORD_WIDTH-1:0]      far_y,
	output logic signed [COORD_WIDTH-1:0]      far_z,
	output logic                               range_flag
);

	// Widths of every intermediate follow from the coordinate and form widths.
	// d is start minus centre; f = Q.d and g = Q.heading floored to Q.16; then
	// c, h and a come out exact in Q.24, and the quarter discriminant in Q.48.
	localparam int CW   = COORD_WIDTH;
	localparam int FW   = FORM_WIDTH;
	localparam int FIX  = rei_pkg::FIX_SHIFT;
	localparam int DW   = CW + 1;
	localparam int PDW  = FW + DW;
	localparam int PEW  = FW + CW;
	localparam int FAW  = PDW + 2;
	localparam int GAW  = PEW + 2;
	localparam int FSW  = FAW - FIX;
	localparam int GSW  = GAW - FIX;
	localparam int CQB  = DW + FSW + 3;
	localparam int CQW  = (CQB > rei_pkg::ONE_SHIFT + 2) ? CQB : rei_pkg::ONE_SHIFT + 2;
	localparam int HW   = CW + FSW + 2;
	localparam int AW   = CW + GSW + 2;
	localparam int MAC  = (AW > CQW) ? AW : CQW;
	localparam int DSW  = ((HW > MAC) ? 2*HW : 2*MAC) + 1;
	localparam int NP   = DSW / 2;
	localparam int NW0  = (HW > NP + 1) ? HW : NP + 1;
	localparam int NW   = NW0 + 1;
	localparam int TQ   = CW + 17;
	localparam int TW   = TQ + 2;
	localparam int DVL  = TQ + 3;
	localparam int PW   = CW + TW + 1;

	localparam logic signed [CQW-1:0] CQ_BIAS  = -(CQW'(1) << rei_pkg::ONE_SHIFT);
	localparam logic signed [PW-1:0]  ROUND    = PW'(1) << (FIX - 1);
	localparam logic signed [PW-1:0]  SAT_HI   = PW'((PW'(1) << (CW - 1)) - PW'(1));
	localparam logic signed [PW-1:0]  SAT_LO   = -(PW'(1) << (CW - 1));

	// Symmetric form: entry (i, j) lives in register FMAP[i][j].
	localparam int FMAP [3][3] = '{'{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};

	// The whole datapath is a pipeline with no back pressure, so a request is
	// taken on every cycle that start is high.
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Configuration registers. Writes to index seven are dropped.
	// ------------------------------------------------------------------
	logic [FW-1:0]   form_q [6];
	logic [3*CW-1:0] centre_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q[0] <= FW'(64'd1 << rei_pkg::ONE_SHIFT);
			form_q[1] <= FW'(64'd1 << rei_pkg::ONE_SHIFT);
			form_q[2] <= FW'(64'd1 << rei_pkg::ONE_SHIFT);
			form_q[3] <= '0;
			form_q[4] <= '0;
			form_q[5] <= '0;
			centre_q  <= '0;
		end else if (cfg_we) begin
			unique case (rei_pkg::reg_idx_t'(cfg_addr))
				rei_pkg::REG_FORM_XX: form_q[0] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_FORM_YY: form_q[1] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_FORM_ZZ: form_q[2] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_FORM_XY: form_q[3] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_FORM_XZ: form_q[4] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_FORM_YZ: form_q[5] <= cfg_wdata[FW-1:0];
				rei_pkg::REG_CENTRE:  centre_q  <= cfg_wdata[3*CW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: register the request and form d = start - centre.
	// ------------------------------------------------------------------
	logic [CW-1:0] in_s [3];
	logic [CW-1:0] in_e [3];

	always_comb begin
		in_s[0] = start_x;
		in_s[1] = start_y;
		in_s[2] = start_z;
		in_e[0] = heading_x;
		in_e[1] = heading_y;
		in_e[2] = heading_z;
	end

	logic          v_s1;
	logic [CW-1:0] s_s1 [3];
	logic [CW-1:0] e_s1 [3];
	logic [DW-1:0] d_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i] <= in_s[i];
			e_s1[i] <= in_e[i];
			d_s1[i] <= DW'($signed(in_s[i])) - DW'($signed(centre_q[i*CW +: CW]));
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the eighteen products of the form with d and with heading.
	// ------------------------------------------------------------------
	logic           v_s2;
	logic [CW-1:0]  s_s2 [3];
	logic [CW-1:0]  e_s2 [3];
	logic [DW-1:0]  d_s2 [3];
	logic [PDW-1:0] pd_s2 [3][3];
	logic [PEW-1:0] pe_s2 [3][3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s2[i] <= s_s1[i];
			e_s2[i] <= e_s1[i];
			d_s2[i] <= d_s1[i];
			for (int j = 0; j < 3; j++) begin
				pd_s2[i][j] <= PDW'($signed(form_q[FMAP[i][j]])) * PDW'($signed(d_s1[j]));
				pe_s2[i][j] <= PEW'($signed(form_q[FMAP[i][j]])) * PEW'($signed(e_s1[j]));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: row sums, floored from Q.32 to Q.16.
	// ------------------------------------------------------------------
	logic signed [FAW-1:0] fa [3];
	logic signed [GAW-1:0] ga [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fa[i] = FAW'($signed(pd_s2[i][0])) + FAW'($signed(pd_s2[i][1]))
				+ FAW'($signed(pd_s2[i][2]));
			ga[i] = GAW'($signed(pe_s2[i][0])) + GAW'($signed(pe_s2[i][1]))
				+ GAW'($signed(pe_s2[i][2]));
		end
	end

	logic           v_s3;
	logic [CW-1:0]  s_s3 [3];
	logic [CW-1:0]  e_s3 [3];
	logic [DW-1:0]  d_s3 [3];
	logic [FSW-1:0] f_s3 [3];
	logic [GSW-1:0] g_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s3[i] <= s_s2[i];
			e_s3[i] <= e_s2[i];
			d_s3[i] <= d_s2[i];
			f_s3[i] <= FSW'(fa[i] >>> FIX);
			g_s3[i] <= GSW'(ga[i] >>> FIX);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: products for c, h and a.
	// ------------------------------------------------------------------
	logic                v_s4;
	logic [CW-1:0]       s_s4 [3];
	logic [CW-1:0]       e_s4 [3];
	logic [DW+FSW-1:0]   df_s4 [3];
	logic [CW+FSW-1:0]   ef_s4 [3];
	logic [CW+GSW-1:0]   eg_s4 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s4[i]  <= s_s3[i];
			e_s4[i]  <= e_s3[i];
			df_s4[i] <= (DW+FSW)'($signed(d_s3[i])) * (DW+FSW)'($signed(f_s3[i]));
			ef_s4[i] <= (CW+FSW)'($signed(e_s3[i])) * (CW+FSW)'($signed(f_s3[i]));
			eg_s4[i] <= (CW+GSW)'($signed(e_s3[i])) * (CW+GSW)'($signed(g_s3[i]));
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: c = d.Q.d - 1, h = heading.Q.d, a = heading.Q.heading.
	// ------------------------------------------------------------------
	logic          v_s5;
	logic [CW-1:0] s_s5 [3];
	logic [CW-1:0] e_s5 [3];
	logic [CQW-1:0] cq_s5;
	logic [HW-1:0]  h_s5;
	logic [AW-1:0]  a_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s5[i] <= s_s4[i];
			e_s5[i] <= e_s4[i];
		end
		cq_s5 <= CQ_BIAS + CQW'($signed(df_s4[0])) + CQW'($signed(df_s4[1]))
			+ CQW'($signed(df_s4[2]));
		h_s5  <= HW'($signed(ef_s4[0])) + HW'($signed(ef_s4[1])) + HW'($signed(ef_s4[2]));
		a_s5  <= AW'($signed(eg_s4[0])) + AW'($signed(eg_s4[1])) + AW'($signed(eg_s4[2]));
	end

	// ------------------------------------------------------------------
	// Stage 6: magnitudes and signs ahead of the wide multipliers. The
	// per-ray data that rides along the rest of the pipe is bundled here.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [2:0][CW-1:0] s;
		logic [2:0][CW-1:0] e;
		logic [HW-1:0]      h;
		logic [AW-1:0]      a;
		logic               azero;
		logic               dneg;
		logic               dzero;
	} side_t;

	logic signed [HW:0]  hx;
	logic signed [AW:0]  ax;
	logic signed [CQW:0] cx;

	always_comb begin
		hx = (HW+1)'($signed(h_s5));
		ax = (AW+1)'($signed(a_s5));
		cx = (CQW+1)'($signed(cq_s5));
	end

	logic          v_s6;
	side_t         side_s6;
	logic [HW-1:0] hmag_s6;
	logic [MAC-1:0] amag_s6;
	logic [MAC-1:0] cmag_s6;
	logic          acneg_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			side_s6.s[i] <= s_s5[i];
			side_s6.e[i] <= e_s5[i];
		end
		side_s6.h     <= h_s5;
		side_s6.a     <= a_s5;
		side_s6.azero <= (a_s5 == '0);
		side_s6.dneg  <= 1'b0;
		side_s6.dzero <= 1'b0;
		hmag_s6  <= HW'((hx < 0) ? -hx : hx);
		amag_s6  <= MAC'((ax < 0) ? -ax : ax);
		cmag_s6  <= MAC'((cx < 0) ? -cx : cx);
		acneg_s6 <= a_s5[AW-1] ^ cq_s5[CQW-1];
	end

	// ------------------------------------------------------------------
	// Stages 7 and 8: h*h and |a|*|c| through split multipliers.
	// ------------------------------------------------------------------
	logic [2*HW-1:0]  hh_s8;
	logic [2*MAC-1:0] ac_s8;

	rei_mul #(.W(HW)) u_mul_hh (
		.clk  (clk),
		.op_a (hmag_s6),
		.op_b (hmag_s6),
		.prod (hh_s8)
	);

	rei_mul #(.W(MAC)) u_mul_ac (
		.clk  (clk),
		.op_a (amag_s6),
		.op_b (cmag_s6),
		.prod (ac_s8)
	);

	logic  v_s7;
	logic  v_s8;
	side_t side_s7;
	side_t side_s8;
	logic  acneg_s7;
	logic  acneg_s8;

	always_ff @(posedge clk) begin
		side_s7  <= side_s6;
		side_s8  <= side_s7;
		acneg_s7 <= acneg_s6;
		acneg_s8 <= acneg_s7;
	end

	// ------------------------------------------------------------------
	// Stage 9: quarter discriminant h*h - a*c, which then enters the
	// square root pipe, two radicand bits per stage.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [2*NP-1:0] rad;
		logic [NP:0]     rem;
		logic [NP-1:0]   root;
		side_t           side;
	} sq_t;

	logic [DSW-1:0] disc;
	side_t          side_in;

	always_comb begin
		if (acneg_s8) begin
			disc = DSW'(hh_s8) + DSW'(ac_s8);
		end else begin
			disc = DSW'(hh_s8) - DSW'(ac_s8);
		end
		side_in       = side_s8;
		side_in.dneg  = disc[DSW-1];
		side_in.dzero = (disc == '0);
	end

	sq_t  sq_sq [NP+1];
	logic v_sq  [NP+1];

	always_ff @(posedge clk) begin
		sq_sq[0].side <= side_in;
		sq_sq[0].rad  <= disc[DSW-1] ? '0 : disc[DSW-2:0];
		sq_sq[0].rem  <= '0;
		sq_sq[0].root <= '0;
	end

	for (genvar k = 0; k < NP; k++) begin : g_sqrt
		logic [NP+2:0] tmp;
		logic [NP+2:0] trial;
		sq_t           nxt;

		always_comb begin
			tmp      = {sq_sq[k].rem, sq_sq[k].rad[2*NP-1 -: 2]};
			trial    = {1'b0, sq_sq[k].root, 2'b01};
			nxt      = sq_sq[k];
			nxt.rad  = {sq_sq[k].rad[2*NP-3:0], 2'b00};
			if (tmp >= trial) begin
				nxt.rem  = (NP+1)'(tmp - trial);
				nxt.root = {sq_sq[k].root[NP-2:0], 1'b1};
			end else begin
				nxt.rem  = (NP+1)'(tmp);
				nxt.root = {sq_sq[k].root[NP-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			sq_sq[k+1] <= nxt;
		end
	end

	// ------------------------------------------------------------------
	// Numerators -h - root and -h + root, split into sign and magnitude.
	// ------------------------------------------------------------------
	logic [NW-1:0] num_n;
	logic [NW-1:0] num_f;
	logic [AW:0]   aw_x;

	always_comb begin
		num_n = -NW'($signed(sq_sq[NP].side.h)) - NW'(sq_sq[NP].root);
		num_f = -NW'($signed(sq_sq[NP].side.h)) + NW'(sq_sq[NP].root);
		aw_x  = (AW+1)'($signed(sq_sq[NP].side.a));
	end

	logic          v_sn;
	side_t         side_sn;
	logic [NW-1:0] nmag_n_sn;
	logic [NW-1:0] nmag_f_sn;
	logic          neg_n_sn;
	logic          neg_f_sn;
	logic [AW-1:0] dmag_sn;

	always_ff @(posedge clk) begin
		side_sn   <= sq_sq[NP].side;
		nmag_n_sn <= num_n[NW-1] ? -num_n : num_n;
		nmag_f_sn <= num_f[NW-1] ? -num_f : num_f;
		neg_n_sn  <= num_n[NW-1] ^ sq_sq[NP].side.a[AW-1];
		neg_f_sn  <= num_f[NW-1] ^ sq_sq[NP].side.a[AW-1];
		dmag_sn   <= AW'(aw_x[AW] ? -aw_x : aw_x);
	end

	// ------------------------------------------------------------------
	// Ray parameters for the near and far points.
	// ------------------------------------------------------------------
	logic signed [TW-1:0] tn;
	logic signed [TW-1:0] tf;

	rei_div #(.NMW(NW), .DNW(AW), .QB(TQ)) u_div_near (
		.clk     (clk),
		.num_mag (nmag_n_sn),
		.den_mag (dmag_sn),
		.neg     (neg_n_sn),
		.t       (tn)
	);

	rei_div #(.NMW(NW), .DNW(AW), .QB(TQ)) u_div_far (
		.clk     (clk),
		.num_mag (nmag_f_sn),
		.den_mag (dmag_sn),
		.neg     (neg_f_sn),
		.t       (tf)
	);

	side_t side_sd [DVL];
	logic  v_sd    [DVL];

	always_ff @(posedge clk) begin
		side_sd[0] <= side_sn;
		for (int k = 1; k < DVL; k++) begin
			side_sd[k] <= side_sd[k-1];
		end
	end

	// ------------------------------------------------------------------
	// heading * t for each axis, Q.24.
	// ------------------------------------------------------------------
	logic          v_sm;
	side_t         side_sm;
	logic [PW-1:0] pn_sm [3];
	logic [PW-1:0] pf_sm [3];

	always_ff @(posedge clk) begin
		side_sm <= side_sd[DVL-1];
		for (int i = 0; i < 3; i++) begin
			pn_sm[i] <= PW'($signed(side_sd[DVL-1].e[i])) * PW'(tn);
			pf_sm[i] <= PW'($signed(side_sd[DVL-1].e[i])) * PW'(tf);
		end
	end

	// ------------------------------------------------------------------
	// Final stage: round to Q.8, add the start point, saturate, and pick
	// the outcome for degenerate, missed, tangent and crossing rays.
	// ------------------------------------------------------------------
	logic signed [PW-1:0] vn [3];
	logic signed [PW-1:0] vf [3];
	logic [CW-1:0]        cn [3];
	logic [CW-1:0]        cf [3];
	logic                 sat;

	always_comb begin
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			vn[i] = (($signed(pn_sm[i]) + ROUND) >>> FIX) + PW'($signed(side_sm.s[i]));
			vf[i] = (($signed(pf_sm[i]) + ROUND) >>> FIX) + PW'($signed(side_sm.s[i]));
			if (vn[i] > SAT_HI) begin
				cn[i] = SAT_HI[CW-1:0];
				sat   = 1'b1;
			end else if (vn[i] < SAT_LO) begin
				cn[i] = SAT_LO[CW-1:0];
				sat   = 1'b1;
			end else begin
				cn[i] = vn[i][CW-1:0];
			end
			if (vf[i] > SAT_HI) begin
				cf[i] = SAT_HI[CW-1:0];
				sat   = 1'b1;
			end else if (vf[i] < SAT_LO) begin
				cf[i] = SAT_LO[CW-1:0];
				sat   = 1'b1;
			end else begin
				cf[i] = vf[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (side_sm.azero) begin
			// A zero a means the heading has no extent under the form.
			hit_count  <= rei_pkg::HIT_NONE;
			near_x     <= '0;
			near_y     <= '0;
			near_z     <= '0;
			far_x      <= '0;
			far_y      <= '0;
			far_z      <= '0;
			range_flag <= 1'b1;
		end else if (side_sm.dneg) begin
			// The ray misses the ellipsoid.
			hit_count  <= rei_pkg::HIT_NONE;
			near_x     <= '0;
			near_y     <= '0;
			near_z     <= '0;
			far_x      <= '0;
			far_y      <= '0;
			far_z      <= '0;
			range_flag <= 1'b0;
		end else begin
			hit_count  <= side_sm.dzero ? rei_pkg::HIT_ONE : rei_pkg::HIT_TWO;
			near_x     <= cn[0];
			near_y     <= cn[1];
			near_z     <= cn[2];
			far_x      <= cf[0];
			far_y      <= cf[1];
			far_z      <= cf[2];
			range_flag <= sat;
		end
	end

	// ------------------------------------------------------------------
	// Valid bits travel alongside the data and are the only reset state
	// in the pipe.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int k = 0; k <= NP; k++) begin
				v_sq[k] <= 1'b0;
			end
			v_sn <= 1'b0;
			for (int k = 0; k < DVL; k++) begin
				v_sd[k] <= 1'b0;
			end
			v_sm <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1    <= start && !busy;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			v_s8    <= v_s7;
			v_sq[0] <= v_s8;
			for (int k = 1; k <= NP; k++) begin
				v_sq[k] <= v_sq[k-1];
			end
			v_sn    <= v_sq[NP];
			v_sd[0] <= v_sn;
			for (int k = 1; k < DVL; k++) begin
				v_sd[k] <= v_sd[k-1];
			end
			v_sm <= v_sd[DVL-1];
			done <= v_sm;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rei_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned W x W multiplier split into four half-width partial products.
// Registered partial products, then their registered sum.
module rei_mul #(
	parameter int W = 53
) (
	input  wire logic           clk,
	input  wire logic [W-1:0]   op_a,
	input  wire logic [W-1:0]   op_b,
	output logic      [2*W-1:0] prod
);

	localparam int L = (W + 1) / 2;
	localparam int H = W - L;

	logic [2*L-1:0] ll_s1;
	logic [L+H-1:0] lh_s1;
	logic [L+H-1:0] hl_s1;
	logic [2*H-1:0] hh_s1;

	always_ff @(posedge clk) begin
		ll_s1 <= (2*L)'(op_a[L-1:0]) * (2*L)'(op_b[L-1:0]);
		lh_s1 <= (L+H)'(op_a[L-1:0]) * (L+H)'(op_b[W-1:L]);
		hl_s1 <= (L+H)'(op_a[W-1:L]) * (L+H)'(op_b[L-1:0]);
		hh_s1 <= (2*H)'(op_a[W-1:L]) * (2*H)'(op_b[W-1:L]);
	end

	always_ff @(posedge clk) begin
		prod <= (2*W)'(ll_s1)
			+ ((2*W)'(lh_s1) << L)
			+ ((2*W)'(hl_s1) << L)
			+ ((2*W)'(hh_s1) << (2*L));
	end

endmodule

`default_nettype wire

// File: rtl/core/rei_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider for the ray parameter. The quotient of
// (num << 16) / den is clamped to 2^QB and signed by neg.
// One new division per cycle.
module rei_div #(
	parameter int NMW = 56,
	parameter int DNW = 52,
	parameter int QB  = 33
) (
	input  wire logic              clk,
	input  wire logic [NMW-1:0]    num_mag,
	input  wire logic [DNW-1:0]    den_mag,
	input  wire logic              neg,
	output logic signed [QB+1:0]   t
);

	localparam int NBW = NMW + rei_pkg::FIX_SHIFT;
	localparam int RW0 = (NBW > DNW + QB + 1) ? NBW : DNW + QB + 1;
	localparam int RW  = RW0 + 1;

	typedef struct packed {
		logic [RW-1:0]  rem;
		logic [DNW-1:0] den;
		logic [QB:0]    quo;
		logic           over;
		logic           neg;
	} dstep_t;

	dstep_t step_s [QB+2];

	// The quotient fits QB+1 bits unless the dividend reaches den << (QB+1);
	// that case clamps anyway.
	always_ff @(posedge clk) begin
		step_s[0].rem  <= RW'(num_mag) << rei_pkg::FIX_SHIFT;
		step_s[0].den  <= den_mag;
		step_s[0].quo  <= '0;
		step_s[0].over <= (RW'(num_mag) << rei_pkg::FIX_SHIFT) >= (RW'(den_mag) << (QB + 1));
		step_s[0].neg  <= neg;
	end

	for (genvar k = 0; k <= QB; k++) begin : g_step
		dstep_t nxt;
		logic [RW-1:0] dd;

		always_comb begin
			dd  = RW'(step_s[k].den) << (QB - k);
			nxt = step_s[k];
			if (step_s[k].rem >= dd) begin
				nxt.rem = step_s[k].rem - dd;
				nxt.quo = {step_s[k].quo[QB-1:0], 1'b1};
			end else begin
				nxt.quo = {step_s[k].quo[QB-1:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			step_s[k+1] <= nxt;
		end
	end

	localparam logic [QB:0] LIMIT = (QB+1)'(1) << QB;

	logic [QB:0] mag;

	always_comb begin
		if (step_s[QB+1].over || step_s[QB+1].quo > LIMIT) begin
			mag = LIMIT;
		end else begin
			mag = step_s[QB+1].quo;
		end
	end

	always_ff @(posedge clk) begin
		t <= step_s[QB+1].neg ? -(QB+2)'(mag) : (QB+2)'(mag);
	end

endmodule

`default_nettype wire

// File: verif/tb_ray_ellipsoid_intersection.sv
`timescale 1ns / 1ps

module tb_ray_ellipsoid_intersection;

	// Index that no register answers to; a write there must change nothing.
	localparam logic [2:0] REG_UNUSED = 3'd7;
	// Clamp on the magnitude of the ray parameter t, in Q.16.
	localparam logic signed [127:0] T_LIMIT = 128'sd1 <<< 33;
	// Pipeline depth at the default widths, with some margin on top.
	localparam int DRAIN_CYCLES = 120;

	typedef logic signed [127:0] acc_t;

	// One expected intersection result, laid out like the result ports.
	typedef struct packed {
		logic [1:0]         hits;
		logic signed [15:0] nx, ny, nz, fx, fy, fz;
		logic               flag;
	} crossing_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_addr = '0;
	logic [47:0]       cfg_wdata = '0;
	logic              start = 1'b0;
	logic signed [15:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [15:0] heading_x = '0, heading_y = '0, heading_z = '0;
	logic              busy, done, range_flag;
	logic [1:0]        hit_count;
	logic signed [15:0] near_x, near_y, near_z, far_x, far_y, far_z;

	ray_ellipsoid_intersection uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.heading_x(heading_x), .heading_y(heading_y), .heading_z(heading_z),
		.done(done), .hit_count(hit_count),
		.near_x(near_x), .near_y(near_y), .near_z(near_z),
		.far_x(far_x), .far_y(far_y), .far_z(far_z),
		.range_flag(range_flag)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Our own copy of the configuration: six form entries in register order and the centre.
	logic signed [31:0] form_q [6];
	logic [47:0]        centre_q;

	crossing_t pending_hits[$];
	int        mismatches = 0;
	int        idle_pct = 0;

	// t = num / den in Q.16, truncated toward zero and clamped in magnitude.
	function automatic acc_t ray_t(input acc_t num, input acc_t den);
		acc_t un, ud, qv;
		logic neg;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		qv = (un <<< 16) / ud;
		if (qv > T_LIMIT)
			qv = T_LIMIT;
		return neg ? -qv : qv;
	endfunction

	// One coordinate of start + heading * t, rounded to Q.8 and saturated.
	function automatic logic signed [15:0] ray_point(input acc_t p0, input acc_t dir,
			input acc_t t, inout logic flag);
		acc_t v;
		v = p0 + ((dir * t + (128'sd1 <<< 15)) >>> 16);
		if (v > 32767) begin
			v = 32767;
			flag = 1'b1;
		end
		if (v < -32768) begin
			v = -32768;
			flag = 1'b1;
		end
		return v[15:0];
	endfunction

	// Full prediction for one ray against the current ellipsoid.
	function automatic crossing_t trace_ray(input logic signed [15:0] sx, sy, sz,
			input logic signed [15:0] ex, ey, ez);
		acc_t q[3][3];
		acc_t sv[3], ev[3], dv[3], fv[3], gv[3];
		acc_t fa, ga, cq, hq, aq, disc, root, cand, tn, tf;
		crossing_t r;
		logic flag;
		r = '0;
		flag = 1'b0;
		q[0][0] = form_q[rei_pkg::REG_FORM_XX];
		q[1][1] = form_q[rei_pkg::REG_FORM_YY];
		q[2][2] = form_q[rei_pkg::REG_FORM_ZZ];
		q[0][1] = form_q[rei_pkg::REG_FORM_XY];
		q[1][0] = q[0][1];
		q[0][2] = form_q[rei_pkg::REG_FORM_XZ];
		q[2][0] = q[0][2];
		q[1][2] = form_q[rei_pkg::REG_FORM_YZ];
		q[2][1] = q[1][2];
		sv[0] = sx; sv[1] = sy; sv[2] = sz;
		ev[0] = ex; ev[1] = ey; ev[2] = ez;
		for (int i = 0; i < 3; i++)
			dv[i] = sv[i] - acc_t'($signed(centre_q[16*i +: 16]));
		for (int i = 0; i < 3; i++) begin
			fa = 0;
			ga = 0;
			for (int j = 0; j < 3; j++) begin
				fa = fa + q[i][j] * dv[j];
				ga = ga + q[i][j] * ev[j];
			end
			fv[i] = fa >>> 16;
			gv[i] = ga >>> 16;
		end
		cq = -(128'sd1 <<< 24);
		hq = 0;
		aq = 0;
		for (int i = 0; i < 3; i++) begin
			cq = cq + dv[i] * fv[i];
			hq = hq + ev[i] * fv[i];
			aq = aq + ev[i] * gv[i];
		end
		// A degenerate direction reports no hit but raises the flag.
		if (aq == 0) begin
			r.flag = 1'b1;
			return r;
		end
		disc = hq * hq - aq * cq;
		// A missed ray leaves every field at zero.
		if (disc < 0)
			return r;
		root = 0;
		for (int b = 62; b >= 0; b--) begin
			cand = root | (128'sd1 <<< b);
			if (cand * cand <= disc)
				root = cand;
		end
		tn = ray_t(-hq - root, aq);
		tf = ray_t(-hq + root, aq);
		r.hits = (disc == 0) ? rei_pkg::HIT_ONE : rei_pkg::HIT_TWO;
		r.nx = ray_point(sv[0], ev[0], tn, flag);
		r.ny = ray_point(sv[1], ev[1], tn, flag);
		r.nz = ray_point(sv[2], ev[2], tn, flag);
		r.fx = ray_point(sv[0], ev[0], tf, flag);
		r.fy = ray_point(sv[1], ev[1], tf, flag);
		r.fz = ray_point(sv[2], ev[2], tf, flag);
		r.flag = flag;
		return r;
	endfunction

	// Present one request and hold it until the block takes it. Start stays high
	// afterwards, unless an idle gap is drawn, so that back-to-back requests need no extra edge.
	task automatic cast_ray(input logic signed [15:0] sx, sy, sz, ex, ey, ez);
		start <= 1'b1;
		start_x <= sx;
		start_y <= sy;
		start_z <= sz;
		heading_x <= ex;
		heading_y <= ey;
		heading_z <= ez;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		pending_hits.push_back(trace_ray(sx, sy, sz, ex, ey, ez));
		// The sender sometimes leaves gaps of idle cycles between requests, so that on
		// average idle_pct of all cycles carry no request.
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Let every outstanding request come back and the pipeline empty out.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Register writes only happen with the block idle; cfg_we stays high across
	// a whole burst of writes and drops once at the end.
	task automatic load_ellipsoid(input logic signed [31:0] xx, yy, zz, xy, xz, yz,
			input logic [47:0] centre);
		logic [47:0] vals[7];
		drain();
		vals[0] = {{16{xx[31]}}, xx};
		vals[1] = {{16{yy[31]}}, yy};
		vals[2] = {{16{zz[31]}}, zz};
		vals[3] = {{16{xy[31]}}, xy};
		vals[4] = {{16{xz[31]}}, xz};
		vals[5] = {{16{yz[31]}}, yz};
		vals[6] = centre;
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			if (i < 6)
				form_q[i] = vals[i][31:0];
			else
				centre_q = vals[i];
		end
		// A write to the unused index carries junk and must be ignored.
		cfg_addr <= REG_UNUSED;
		cfg_wdata <= 48'({$urandom, $urandom});
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly rays aimed roughly at the centre from nearby, so that hits are common;
	// the rest are full-range noise that exercises every input bit, and some have a zero heading.
	task automatic cast_random_ray;
		logic signed [15:0] s[3], e[3];
		int off;
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(7) == 0) begin
				s[i] = 16'($urandom);
				e[i] = 16'($urandom);
			end else begin
				off = int'($urandom_range(0, 1536)) - 768;
				s[i] = 16'($signed(centre_q[16*i +: 16]) + off);
				e[i] = 16'(-off + int'($urandom_range(0, 256)) - 128);
			end
		end
		if ($urandom_range(40) == 0) begin
			e[0] = 0;
			e[1] = 0;
			e[2] = 0;
		end
		cast_ray(s[0], s[1], s[2], e[0], e[1], e[2]);
	endtask

	// Compare each result strobe against the oldest expected request.
	always @(posedge clk) begin
		crossing_t want;
		if (done) begin
			if (pending_hits.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = pending_hits.pop_front();
				if (hit_count !== want.hits) begin
					$error("hit_count: expected %0d, got %0d", want.hits, hit_count);
					mismatches++;
				end
				if (near_x !== want.nx) begin
					$error("near_x: expected %0d, got %0d", want.nx, near_x);
					mismatches++;
				end
				if (near_y !== want.ny) begin
					$error("near_y: expected %0d, got %0d", want.ny, near_y);
					mismatches++;
				end
				if (near_z !== want.nz) begin
					$error("near_z: expected %0d, got %0d", want.nz, near_z);
					mismatches++;
				end
				if (far_x !== want.fx) begin
					$error("far_x: expected %0d, got %0d", want.fx, far_x);
					mismatches++;
				end
				if (far_y !== want.fy) begin
					$error("far_y: expected %0d, got %0d", want.fy, far_y);
					mismatches++;
				end
				if (far_z !== want.fz) begin
					$error("far_z: expected %0d, got %0d", want.fz, far_z);
					mismatches++;
				end
				if (range_flag !== want.flag) begin
					$error("range_flag: expected %0d, got %0d", want.flag, range_flag);
					mismatches++;
				end
			end
		end
	end

	// Directed rays against the unit sphere: crossing, tangent, miss, zero heading,
	// and the extremes of every input field; then a shifted sphere and an indefinite form.
	task automatic test_directed;
		idle_pct = 0;
		load_ellipsoid(32'sd1 <<< 24, 32'sd1 <<< 24, 32'sd1 <<< 24, 0, 0, 0, 48'd0);
		cast_ray(-768, 0, 0, 256, 0, 0);
		cast_ray(0, -768, 0, 0, 512, 0);
		cast_ray(0, 0, 768, 0, 0, -256);
		cast_ray(-512, 256, 0, 256, 0, 0);
		cast_ray(-512, 512, 0, 256, 0, 0);
		cast_ray(100, 200, 300, 0, 0, 0);
		cast_ray(-32768, -32768, -32768, 32767, 32767, 32767);
		cast_ray(32767, 32767, 32767, -32768, -32768, -32768);
		cast_ray(32767, 0, 0, -32768, 0, 0);
		cast_ray(-32768, 0, 0, 1, 0, 0);
		cast_ray(0, 0, 0, 32767, -32768, 1);
		cast_ray(0, 0, 0, -1, -1, -1);
		cast_ray(-1, -1, -1, 1, 1, 1);
		cast_ray(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
		// Centre near the top of the range, so the far point saturates.
		load_ellipsoid(32'sd1 <<< 24, 32'sd1 <<< 24, 32'sd1 <<< 24, 0, 0, 0,
			{16'sd0, 16'sd0, 16'sd32600});
		cast_ray(32000, 0, 0, 256, 0, 0);
		cast_ray(32600, 0, 0, 0, 1, 0);
		// An indefinite form, where near may lie at the larger t.
		load_ellipsoid(-(32'sd1 <<< 24), 32'sd1 <<< 24, 32'sd1 <<< 24, 0, 0, 0, 48'd0);
		cast_ray(-768, 0, 0, 256, 0, 0);
		cast_ray(0, -768, 0, 128, 256, 0);
		cast_ray(0, 0, 0, 256, 256, 0);
	endtask

	// One of several ellipsoid settings, the register extremes among them.
	task automatic pick_ellipsoid(input int k);
		case (k)
			0: begin
				load_ellipsoid(32'sd1 <<< 22, 32'sd1 <<< 24, 32'sd1 <<< 26,
					32'sd1 <<< 20, -(32'sd1 <<< 21), 32'sd3 <<< 19,
					{16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
					 16'($urandom_range(0, 4096))});
			end
			1: begin
				load_ellipsoid($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
					$urandom_range(0, 1 << 26),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					48'({$urandom, $urandom}));
			end
			2: begin
				load_ellipsoid(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
					32'sh80000000, 32'sh80000000, 32'sh80000000, 48'hFFFF_FFFF_FFFF);
			end
			3: begin
				load_ellipsoid(32'sh80000000, 32'sh80000000, 32'sh80000000,
					32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 48'h8000_7FFF_8000);
			end
			4: begin
				load_ellipsoid(0, 0, 0, 0, 0, 0, 48'h0000_0000_0000);
			end
			default: begin
				load_ellipsoid(-(32'sd1 <<< 24), 32'sd1 <<< 25, $urandom, $urandom,
					$urandom, $urandom, 48'({$urandom, $urandom}));
			end
		endcase
	endtask

	// Random rays under each setting in turn; halfway through the third setting, the sender
	// holds off until every outstanding request has returned.
	task automatic test_random(input int per_setting, input int pct);
		idle_pct = pct;
		for (int k = 0; k < 6; k++) begin
			pick_ellipsoid(k);
			for (int n = 0; n < per_setting; n++) begin
				cast_random_ray();
				if (k == 2 && n == per_setting / 2) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending_hits.size() != 0)
						@(posedge clk);
				end
			end
		end
	endtask

	initial begin
		form_q[rei_pkg::REG_FORM_XX] = 32'sd1 <<< 24;
		form_q[rei_pkg::REG_FORM_YY] = 32'sd1 <<< 24;
		form_q[rei_pkg::REG_FORM_ZZ] = 32'sd1 <<< 24;
		form_q[rei_pkg::REG_FORM_XY] = 0;
		form_q[rei_pkg::REG_FORM_XZ] = 0;
		form_q[rei_pkg::REG_FORM_YZ] = 0;
		centre_q = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(60, 31);
		test_random(60, 68);
		test_random(60, 0);
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rei_pkg.sv
rtl/core/rei_mul.sv
rtl/core/rei_div.sv
rtl/core/ray_ellipsoid_intersection.sv
verif/tb_ray_ellipsoid_intersection.sv
